>>> hdl/dtse_pkg.sv
// shared types and constants for the date and time set-mode editor
package dtse_pkg;

  // request codes carried in the input tuser
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_PREV  = 3'd1,
    REQ_NEXT  = 3'd2,
    REQ_PLUS  = 3'd3,
    REQ_MINUS = 3'd4,
    REQ_DIGIT = 3'd5,
    REQ_SET   = 3'd6
  } req_e;

  // selected field codes
  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  // status codes
  localparam logic [1:0] STS_NONE    = 2'd0;
  localparam logic [1:0] STS_NOTHING = 2'd1;
  localparam logic [1:0] STS_SET     = 2'd2;

  localparam logic [11:0] YEAR_LOW  = 12'd2000;
  localparam logic [11:0] YEAR_HIGH = 12'd2099;
  localparam logic [15:0] LAPSE_RESET = 16'd30000;

  // calendar fields, shared by the frozen time and the edit copy
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // editor state
  typedef struct packed {
    logic        active;
    logic [2:0]  field;
    logic [2:0]  count;
    cal_t        cal;
    logic [15:0] lapse;
  } state_t;

  // one input beat after the input register
  typedef struct packed {
    logic [2:0] req;
    logic [3:0] digit;
    cal_t       now;
  } item_t;

  // one result beat
  typedef struct packed {
    logic       editing;
    logic [2:0] field;
    cal_t       cal;
    logic       commit;
    logic [1:0] status;
  } res_t;

endpackage

>>> hdl/dtse_step.sv
// next-state and result logic for one editor request
module dtse_step (
  input  dtse_pkg::state_t st_i,
  input  dtse_pkg::item_t  item_i,
  input  logic [15:0]      lapse_cfg_i,
  output dtse_pkg::state_t st_o,
  output dtse_pkg::res_t   res_o
);
  import dtse_pkg::*;

  // y divisible by 25, via reciprocal multiply and check
  function automatic logic div25(logic [11:0] y);
    logic [25:0] prod;
    logic [7:0]  q;
    logic [12:0] back;
    prod = 26'(y) * 26'd10486;
    q    = prod[25:18];
    back = 13'(q) * 13'd25;
    return back == {1'b0, y};
  endfunction

  // days in month, months outside one to twelve count as 31
  function automatic logic [4:0] month_days(logic [11:0] y, logic [3:0] m);
    logic leap;
    logic [4:0] len;
    leap = (y[1:0] == 2'b00) && (!div25(y) || (y[3:0] == 4'd0));
    case (m) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // reduce a value below three times the modulus
  function automatic logic [6:0] wrap2(logic [6:0] v, logic [6:0] m);
    logic [6:0] r;
    r = v;
    if (r >= m) r = r - m;
    if (r >= m) r = r - m;
    return r;
  endfunction

  state_t      base;
  state_t      nx;
  logic        entering;
  logic        commit;
  logic [1:0]  status;
  logic [2:0]  f;
  logic [4:0]  days_old;
  logic [4:0]  days_new;
  logic [11:0] slot;
  logic [14:0] v;
  logic [14:0] lo;
  logic [14:0] hi;
  logic [2:0]  cnt;
  logic        full;
  logic        up;
  logic [12:0] yinc;
  logic [11:0] ydec;
  logic [6:0]  tmp;

  always_comb begin
    // freeze the current time on the first key press
    entering = !st_i.active
               && (item_i.req inside {REQ_PREV, REQ_NEXT, REQ_PLUS, REQ_MINUS, REQ_DIGIT});
    base = st_i;
    if (entering) begin
      base.cal    = item_i.now;
      base.active = 1'b1;
      base.field  = FLD_YEAR;
      base.count  = 3'd0;
    end
    nx     = base;
    commit = 1'b0;
    status = STS_NONE;
    f      = (base.field >= 3'd6) ? base.field - 3'd6 : base.field;
    days_old = month_days(base.cal.year, base.cal.month);
    days_new = days_old;
    up   = (item_i.req == REQ_PLUS);
    yinc = {1'b0, base.cal.year} + 13'd1;
    ydec = base.cal.year - 12'd1;
    slot = '0;
    v    = '0;
    lo   = '0;
    hi   = 15'd59;
    cnt  = '0;
    full = 1'b0;
    tmp  = '0;

    unique case (item_i.req)
      REQ_TICK: begin
        if (st_i.active) begin
          if (st_i.lapse <= 16'd1) begin
            nx.lapse  = '0;
            nx.active = 1'b0;
          end else begin
            nx.lapse = st_i.lapse - 16'd1;
          end
        end
      end
      REQ_PREV, REQ_NEXT: begin
        if (!entering) begin
          if (item_i.req == REQ_NEXT) nx.field = (f == FLD_SECOND) ? FLD_YEAR : f + 3'd1;
          else                        nx.field = (f == FLD_YEAR) ? FLD_SECOND : f - 3'd1;
          nx.count = 3'd0;
        end
        nx.lapse = lapse_cfg_i;
      end
      REQ_PLUS, REQ_MINUS: begin
        if (!entering) begin
          nx.count = 3'd0;
          case (base.field)
            FLD_YEAR: begin
              if (up) nx.cal.year = (yinc > 13'(YEAR_HIGH) || yinc < 13'(YEAR_LOW))
                                    ? YEAR_LOW : yinc[11:0];
              else    nx.cal.year = (base.cal.year < YEAR_LOW + 12'd1 || ydec > YEAR_HIGH)
                                    ? YEAR_HIGH : ydec;
            end
            FLD_MONTH: begin
              tmp = wrap2(7'(base.cal.month) + (up ? 7'd12 : 7'd10), 7'd12);
              nx.cal.month = tmp[3:0] + 4'd1;
            end
            FLD_DAY: begin
              if (up) nx.cal.day = (base.cal.day + 5'd1 > days_old || base.cal.day == 5'd31)
                                   ? 5'd1 : base.cal.day + 5'd1;
              else    nx.cal.day = (base.cal.day < 5'd2 || base.cal.day - 5'd1 > days_old)
                                   ? days_old : base.cal.day - 5'd1;
            end
            FLD_HOUR: begin
              tmp = wrap2(7'(base.cal.hour) + (up ? 7'd25 : 7'd23), 7'd24);
              nx.cal.hour = tmp[4:0];
            end
            FLD_MINUTE: begin
              tmp = wrap2(7'(base.cal.minute) + (up ? 7'd61 : 7'd59), 7'd60);
              nx.cal.minute = tmp[5:0];
            end
            FLD_SECOND: begin
              tmp = wrap2(7'(base.cal.second) + (up ? 7'd61 : 7'd59), 7'd60);
              nx.cal.second = tmp[5:0];
            end
            default: ;
          endcase
          // keep the day within the month
          days_new = month_days(nx.cal.year, nx.cal.month);
          if (nx.cal.day > days_new) nx.cal.day = days_new;
        end
        nx.lapse = lapse_cfg_i;
      end
      REQ_DIGIT: begin
        nx.field = f;
        case (f)
          FLD_YEAR:   slot = base.cal.year;
          FLD_MONTH:  slot = 12'(base.cal.month);
          FLD_DAY:    slot = 12'(base.cal.day);
          FLD_HOUR:   slot = 12'(base.cal.hour);
          FLD_MINUTE: slot = 12'(base.cal.minute);
          default:    slot = 12'(base.cal.second);
        endcase
        // shift the digit in from the right
        v    = (base.count == 3'd0) ? 15'(item_i.digit)
                                    : 15'(slot) * 15'd10 + 15'(item_i.digit);
        cnt  = base.count + 3'd1;
        full = (f == FLD_YEAR) ? (cnt >= 3'd4) : (cnt >= 3'd2);
        if (full) begin
          case (f)
            FLD_YEAR:  begin lo = 15'(YEAR_LOW); hi = 15'(YEAR_HIGH); end
            FLD_MONTH: begin lo = 15'd1; hi = 15'd12; end
            FLD_DAY:   begin lo = 15'd1; hi = 15'(days_old); end
            FLD_HOUR:  hi = 15'd23;
            default: ;
          endcase
          if (v < lo) v = lo;
          if (v > hi) v = hi;
        end
        case (f)
          FLD_YEAR:   nx.cal.year   = v[11:0];
          FLD_MONTH:  nx.cal.month  = v[3:0];
          FLD_DAY:    nx.cal.day    = v[4:0];
          FLD_HOUR:   nx.cal.hour   = v[4:0];
          FLD_MINUTE: nx.cal.minute = v[5:0];
          default:    nx.cal.second = v[5:0];
        endcase
        nx.count = cnt;
        if (full) begin
          if (f != FLD_SECOND) nx.field = f + 3'd1;
          nx.count = 3'd0;
        end
        nx.lapse = lapse_cfg_i;
      end
      REQ_SET: begin
        if (!st_i.active) begin
          status = STS_NOTHING;
        end else begin
          commit    = 1'b1;
          status    = STS_SET;
          nx.active = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign st_o = nx;

  // result beat from the updated state
  assign res_o.editing = nx.active;
  assign res_o.field   = nx.field;
  assign res_o.cal     = nx.cal;
  assign res_o.commit  = commit;
  assign res_o.status  = status;

endmodule

>>> hdl/date_time_set_editor_top.sv
// top level of the date and time set-mode editor
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid_i/tready_o     tuser request, tdata digit and now
//  m_axis    out        m_axis_tvalid_o/tready_i     tdata edit copy, commit, status
//  cfg       in         cfg_we_i                     cfg_wdata_i edit lapse in ticks
//
// one beat a cycle sustained while m_axis_tready_i stays high; a result passes
// the input register, then the state update and the result register.
// reset clears the edit state to the year 2000 copy and sets the configured lapse to 30000.
// a stalled result holds the result register; the input register still
// takes one more beat, then tready falls until the result is taken.
module date_time_set_editor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // req_type [2:0]
  input  logic [2:0]  s_axis_tuser_i,
  // digit [3:0], now_year [15:4], now_month [19:16], now_day [24:20],
  // now_hour [29:25], now_minute [35:30], now_second [41:36], zero fill
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // editing [0], selected_field [3:1], edit_year [15:4], edit_month [19:16],
  // edit_day [24:20], edit_hour [29:25], edit_minute [35:30],
  // edit_second [41:36], commit [42], status [44:43], zero fill
  output logic [47:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import dtse_pkg::*;

  logic        in_valid_q;
  item_t       in_q;
  logic        out_valid_q;
  res_t        out_q;
  state_t      st_q;
  state_t      st_d;
  res_t        res_d;
  logic [15:0] lapse_cfg_q;
  logic        adv;
  logic        in_take;
  item_t       item_d;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || !out_valid_q || m_axis_tready_i;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // unpack the input beat
  assign item_d.req        = s_axis_tuser_i;
  assign item_d.digit      = s_axis_tdata_i[3:0];
  assign item_d.now.year   = s_axis_tdata_i[15:4];
  assign item_d.now.month  = s_axis_tdata_i[19:16];
  assign item_d.now.day    = s_axis_tdata_i[24:20];
  assign item_d.now.hour   = s_axis_tdata_i[29:25];
  assign item_d.now.minute = s_axis_tdata_i[35:30];
  assign item_d.now.second = s_axis_tdata_i[41:36];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lapse_cfg_q <= LAPSE_RESET;
    end else if (cfg_we_i) begin
      lapse_cfg_q <= cfg_wdata_i;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= item_d;
    end
  end

  dtse_step u_step (
    .st_i        (st_q),
    .item_i      (in_q),
    .lapse_cfg_i (lapse_cfg_q),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  // editor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.active     <= 1'b0;
      st_q.field      <= FLD_YEAR;
      st_q.count      <= 3'd0;
      st_q.cal.year   <= YEAR_LOW;
      st_q.cal.month  <= 4'd1;
      st_q.cal.day    <= 5'd1;
      st_q.cal.hour   <= 5'd0;
      st_q.cal.minute <= 6'd0;
      st_q.cal.second <= 6'd0;
      st_q.lapse      <= 16'd0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.status, out_q.commit, out_q.cal.second,
                            out_q.cal.minute, out_q.cal.hour, out_q.cal.day,
                            out_q.cal.month, out_q.cal.year, out_q.field, out_q.editing};

endmodule

>>> tb/sv/tb_date_time_set_editor_top.sv
// testbench for the date and time set-mode editor, predicted edit copy checked beat by beat
module tb_date_time_set_editor_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtse_pkg::*;

  // request code outside the defined set, the block must ignore it
  localparam logic [2:0] REQ_SPARE = 3'd7;
  localparam int NUM_FIELDS = 6;

  // tracks the editor state and holds the result beats still awaited
  class edit_copy_tracker;
    logic [15:0] lapse_ticks;
    logic        active;
    logic [2:0]  field;
    int unsigned typed;
    cal_t        cal;
    logic [15:0] lapse_left;
    logic [47:0] awaited_copies [$];
    int          errors;
    int          checked;

    function new();
      lapse_ticks = LAPSE_RESET;
      active      = 1'b0;
      field       = FLD_YEAR;
      typed       = 0;
      cal.year    = YEAR_LOW;
      cal.month   = 4'd1;
      cal.day     = 5'd1;
      cal.hour    = '0;
      cal.minute  = '0;
      cal.second  = '0;
      lapse_left  = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function int unsigned month_days(int unsigned yr, int unsigned mo);
      int unsigned lens [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (mo < 1 || mo > 12) return 31;
      if (mo == 2) return (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0) ? 29 : 28;
      return lens[mo - 1];
    endfunction

    // first key press while idle takes the current time as the edit copy
    function bit freeze(cal_t now);
      if (active) return 1'b0;
      cal    = now;
      active = 1'b1;
      field  = FLD_YEAR;
      typed  = 0;
      return 1'b1;
    endfunction

    function void move_selection(cal_t now, bit forward);
      int unsigned f;
      if (!freeze(now)) begin
        f = field % NUM_FIELDS;
        f = forward ? (f + 1) % NUM_FIELDS : (f + NUM_FIELDS - 1) % NUM_FIELDS;
        field = 3'(f);
        typed = 0;
      end
      lapse_left = lapse_ticks;
    endfunction

    // plus or minus on the selected field, with wrap, then day clamp
    function void nudge_field(cal_t now, bit up);
      int unsigned v;
      int unsigned last;
      if (freeze(now)) begin
        lapse_left = lapse_ticks;
        return;
      end
      typed = 0;
      case (field)
        FLD_YEAR: begin
          v = cal.year;
          if (up) v = (v + 1 > YEAR_HIGH || v + 1 < YEAR_LOW) ? YEAR_LOW : v + 1;
          else v = (v < YEAR_LOW + 1 || v - 1 > YEAR_HIGH) ? YEAR_HIGH : v - 1;
          cal.year = 12'(v);
        end
        FLD_MONTH: begin
          v = cal.month;
          v = (v + (up ? 12 : 10)) % 12 + 1;
          cal.month = 4'(v);
        end
        FLD_DAY: begin
          last = month_days(cal.year, cal.month);
          v = cal.day;
          if (up) v = (v + 1 > last) ? 1 : v + 1;
          else v = (v < 2 || v - 1 > last) ? last : v - 1;
          cal.day = 5'(v);
        end
        FLD_HOUR: begin
          v = cal.hour;
          cal.hour = 5'((v + (up ? 25 : 23)) % 24);
        end
        FLD_MINUTE: begin
          v = cal.minute;
          cal.minute = 6'((v + (up ? 61 : 59)) % 60);
        end
        FLD_SECOND: begin
          v = cal.second;
          cal.second = 6'((v + (up ? 61 : 59)) % 60);
        end
        default: ;
      endcase
      last = month_days(cal.year, cal.month);
      if (cal.day > last) cal.day = 5'(last);
      lapse_left = lapse_ticks;
    endfunction

    // digit shifts in from the right, clamp and advance once the field is full
    function void type_key(logic [3:0] digit, cal_t now);
      int unsigned f;
      int unsigned len;
      int unsigned v;
      int unsigned lo;
      int unsigned hi;
      bit          full;
      void'(freeze(now));
      f   = field % NUM_FIELDS;
      len = (f == FLD_YEAR) ? 4 : 2;
      case (3'(f))
        FLD_YEAR:   v = cal.year;
        FLD_MONTH:  v = cal.month;
        FLD_DAY:    v = cal.day;
        FLD_HOUR:   v = cal.hour;
        FLD_MINUTE: v = cal.minute;
        default:    v = cal.second;
      endcase
      v = (typed == 0) ? digit : v * 10 + digit;
      typed++;
      full = (typed >= len);
      if (full) begin
        lo = 0;
        hi = 59;
        case (3'(f))
          FLD_YEAR: begin
            lo = YEAR_LOW;
            hi = YEAR_HIGH;
          end
          FLD_MONTH: begin
            lo = 1;
            hi = 12;
          end
          FLD_DAY: begin
            lo = 1;
            hi = month_days(cal.year, cal.month);
          end
          FLD_HOUR: hi = 23;
          default: ;
        endcase
        if (v < lo) v = lo;
        if (v > hi) v = hi;
      end
      case (3'(f))
        FLD_YEAR:   cal.year   = 12'(v);
        FLD_MONTH:  cal.month  = 4'(v);
        FLD_DAY:    cal.day    = 5'(v);
        FLD_HOUR:   cal.hour   = 5'(v);
        FLD_MINUTE: cal.minute = 6'(v);
        default:    cal.second = 6'(v);
      endcase
      field = 3'(f);
      if (full) begin
        if (f + 1 < NUM_FIELDS) field = 3'(f + 1);
        typed = 0;
      end
      lapse_left = lapse_ticks;
    endfunction

    // apply one accepted input beat and queue the result beat it causes
    function void note_key(logic [2:0] req, logic [3:0] digit, cal_t now);
      logic       commit;
      logic [1:0] status;
      commit = 1'b0;
      status = STS_NONE;
      case (req)
        REQ_TICK: begin
          if (active) begin
            if (lapse_left <= 1) begin
              lapse_left = '0;
              active     = 1'b0;
            end else begin
              lapse_left = lapse_left - 16'd1;
            end
          end
        end
        REQ_PREV:  move_selection(now, 1'b0);
        REQ_NEXT:  move_selection(now, 1'b1);
        REQ_PLUS:  nudge_field(now, 1'b1);
        REQ_MINUS: nudge_field(now, 1'b0);
        REQ_DIGIT: type_key(digit, now);
        REQ_SET: begin
          if (!active) begin
            status = STS_NOTHING;
          end else begin
            commit = 1'b1;
            status = STS_SET;
            active = 1'b0;
          end
        end
        default: ;
      endcase
      awaited_copies.push_back({3'b000, status, commit, cal.second, cal.minute, cal.hour,
                                cal.day, cal.month, cal.year, field, active});
    endfunction

    // compare one result beat with the oldest awaited one, field by field
    function void check_display(logic [47:0] got);
      int          lsb [10]   = '{0, 1, 4, 16, 20, 25, 30, 36, 42, 43};
      int          width [10] = '{1, 3, 12, 4, 5, 5, 6, 6, 1, 2};
      string       names [10] = '{"editing", "selected_field", "edit_year", "edit_month",
                                  "edit_day", "edit_hour", "edit_minute", "edit_second",
                                  "commit", "status"};
      logic [47:0] want;
      logic [47:0] mask;
      if (awaited_copies.size() == 0) begin
        errors++;
        if (errors <= 40) $display("%0t: result beat %h with none awaited", $time, got);
        return;
      end
      want = awaited_copies.pop_front();
      for (int i = 0; i < 10; i++) begin
        mask = (48'd1 << width[i]) - 48'd1;
        if (((want >> lsb[i]) & mask) != ((got >> lsb[i]) & mask)) begin
          errors++;
          if (errors <= 40)
            $display("%0t: %s expected %0d actual %0d", $time, names[i],
                     (want >> lsb[i]) & mask, (got >> lsb[i]) & mask);
        end
      end
      checked++;
    endfunction
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        s_valid   = 1'b0;
  logic [2:0]  s_user    = '0;
  logic [47:0] s_data    = '0;
  logic        m_ready   = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [47:0] m_axis_tdata_o;

  edit_copy_tracker copies = new();
  int keys_sent;
  int sender_calm;

  date_time_set_editor_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_user),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // idle length: mostly none or short, a few long, now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] random_digit();
    if ($urandom_range(0, 19) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  // current time, mostly in calendar range, sometimes any bit pattern
  function automatic cal_t random_now();
    cal_t c;
    if ($urandom_range(0, 9) == 0) begin
      c.year   = 12'($urandom);
      c.month  = 4'($urandom);
      c.day    = 5'($urandom);
      c.hour   = 5'($urandom);
      c.minute = 6'($urandom);
      c.second = 6'($urandom);
    end else begin
      c.year   = 12'($urandom_range(1970, 2099));
      c.month  = 4'($urandom_range(1, 12));
      c.day    = 5'($urandom_range(1, 31));
      c.hour   = 5'($urandom_range(0, 23));
      c.minute = 6'($urandom_range(0, 59));
      c.second = 6'($urandom_range(0, 59));
    end
    return c;
  endfunction

  // offer one input beat, note it once taken, then maybe idle
  task automatic send_key(logic [2:0] req, logic [3:0] digit, cal_t now);
    int gap;
    s_valid <= 1'b1;
    s_user  <= req;
    s_data  <= {6'b0, now.second, now.minute, now.hour, now.day, now.month, now.year, digit};
    do @(posedge clk_i); while (!s_axis_tready_o);
    copies.note_key(req, digit, now);
    keys_sent++;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every awaited beat, then wait the number of cycles given
  task automatic settle(int cycles);
    s_valid <= 1'b0;
    while (copies.awaited_copies.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_lapse(logic [15:0] ticks);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    copies.lapse_ticks = ticks;
  endtask

  // one edit session: entry press, random edits, then set, a lapse of ticks or neither
  task automatic edit_session(logic [15:0] lapse);
    req_e entry_keys [5];
    int   steps;
    int   pick;
    cal_t now;
    entry_keys = '{REQ_PREV, REQ_NEXT, REQ_PLUS, REQ_MINUS, REQ_DIGIT};
    now = random_now();
    send_key(entry_keys[$urandom_range(0, 4)], random_digit(), now);
    steps = $urandom_range(2, 20);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_key(pick < 8 ? REQ_PREV : REQ_NEXT, random_digit(), now);
      end else if (pick < 45) begin
        send_key(pick < 30 ? REQ_PLUS : REQ_MINUS, random_digit(), now);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 4)) send_key(REQ_DIGIT, random_digit(), now);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_key(REQ_TICK, random_digit(), now);
      end else begin
        send_key(3'($urandom), 4'($urandom), random_now());
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) send_key(REQ_SET, random_digit(), now);
    else if (pick < 85 && lapse <= 64) repeat (lapse + 1) send_key(REQ_TICK, random_digit(), now);
  endtask

  // stimulus: reset, directed beats, then random phases over several lapse settings
  initial begin : stimulus
    cal_t        top_now;
    cal_t        odd_now;
    logic [15:0] lapse_plan [6];
    lapse_plan  = '{16'd1, 16'd65535, 16'd0, 16'd4, 16'd30, 16'd300};
    top_now     = '{12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};
    odd_now     = '{12'd1970, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63};
    keys_sent   = 0;
    sender_calm = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // set, tick and the spare code while idle
    send_key(REQ_SET, 4'd0, top_now);
    send_key(REQ_TICK, 4'd0, top_now);
    send_key(REQ_SPARE, 4'd9, top_now);
    // plus enters editing only, then wrap year, month and day both ways, hour and second at the top
    send_key(REQ_PLUS, 4'd0, top_now);
    send_key(REQ_PLUS, 4'd0, top_now);
    send_key(REQ_MINUS, 4'd0, top_now);
    send_key(REQ_NEXT, 4'd0, top_now);
    send_key(REQ_PLUS, 4'd0, top_now);
    send_key(REQ_MINUS, 4'd0, top_now);
    send_key(REQ_NEXT, 4'd0, top_now);
    send_key(REQ_PLUS, 4'd0, top_now);
    send_key(REQ_MINUS, 4'd0, top_now);
    send_key(REQ_NEXT, 4'd0, top_now);
    send_key(REQ_PLUS, 4'd0, top_now);
    send_key(REQ_NEXT, 4'd0, top_now);
    send_key(REQ_NEXT, 4'd0, top_now);
    send_key(REQ_PLUS, 4'd0, top_now);
    // selection wraps past second and back past year
    send_key(REQ_NEXT, 4'd0, top_now);
    send_key(REQ_PREV, 4'd0, top_now);
    send_key(REQ_SET, 4'd0, top_now);
    // out-of-range current time, then typed year, month, a clamped leap day
    send_key(REQ_PREV, 4'd0, odd_now);
    send_key(REQ_DIGIT, 4'd2, odd_now);
    send_key(REQ_DIGIT, 4'd0, odd_now);
    send_key(REQ_DIGIT, 4'd2, odd_now);
    send_key(REQ_DIGIT, 4'd4, odd_now);
    send_key(REQ_DIGIT, 4'd0, odd_now);
    send_key(REQ_DIGIT, 4'd2, odd_now);
    send_key(REQ_DIGIT, 4'd3, odd_now);
    send_key(REQ_DIGIT, 4'd1, odd_now);
    // digits above nine, hour clamped once full
    send_key(REQ_DIGIT, 4'd15, odd_now);
    send_key(REQ_DIGIT, 4'd15, odd_now);
    send_key(REQ_SET, 4'd0, odd_now);

    foreach (lapse_plan[p]) begin
      settle(4);
      write_lapse(lapse_plan[p]);
      keys_sent = 0;
      while (keys_sent < 290) begin
        if ($urandom_range(0, 99) < 15) send_key(3'($urandom), 4'($urandom), random_now());
        else edit_session(lapse_plan[p]);
      end
    end

    settle(8);
    if (copies.errors == 0 && copies.awaited_copies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: check taken beats, random stalls and long hold-offs
  initial begin : result_sink
    int hold_left;
    int calm;
    int next_squeeze;
    hold_left    = 0;
    calm         = 0;
    next_squeeze = 150;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) copies.check_display(m_axis_tdata_o);
      if (hold_left == 0 && copies.checked >= next_squeeze) begin
        // long hold-off so the block backs up and drops its input ready
        hold_left    = 120;
        next_squeeze = next_squeeze + 600;
      end else if (hold_left == 0) begin
        hold_left = pick_gap(calm);
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin : watchdog
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
hdl/dtse_pkg.sv
hdl/dtse_step.sv
hdl/date_time_set_editor_top.sv
tb/sv/tb_date_time_set_editor_top.sv
